// ===== rtl/hsat_pkg.sv =====
// ----------------------------------------------------------------------------
// hsat_pkg
// shared types, constants and the hall decode table of the angle tracker
// ----------------------------------------------------------------------------
`default_nettype none

package hsat_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int ANGLE_WIDTH = 32;

   localparam int SAMPLE_W   = 12;
   localparam int HALL_W     = 3;
   localparam int PWM_W      = 16;
   localparam int CURRENT_W  = 16;
   localparam int POS_W      = 3;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int POS_PROD_W = POS_W + CSR_W;
   localparam int SEC_PROD_W = COUNT_WIDTH + CSR_W + 1;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 72;

   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_SAMPLES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_SIZE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE     = 2'd2;

   localparam logic [CSR_W-1:0] CALIB_SAMPLES_RST = 16'd16;
   localparam logic [CSR_W-1:0] SECTOR_SIZE_RST   = 16'd360;
   localparam logic [CSR_W-1:0] STEP_SIZE_RST     = 16'd60;

   localparam logic [POS_W-1:0] POS_WRAP_HIGH = 3'd5;
   localparam logic [POS_W-1:0] POS_WRAP_LOW  = 3'd0;

   localparam logic [POS_W-1:0] HALL_POS_TABLE [0:7] =
      '{3'd0, 3'd0, 3'd2, 3'd1, 3'd4, 3'd5, 3'd3, 3'd6};

   typedef struct packed {
      logic [CURRENT_W-1:0]   current;
      logic [POS_W-1:0]       position;
      logic [COUNT_WIDTH-1:0] count;
      logic                   ready;
      logic                   moved;
      logic                   pwm_neg;
   } trk_type;

endpackage

`default_nettype wire

// ===== rtl/hsat_track.sv =====
// ----------------------------------------------------------------------------
// hsat_track
// calibration countdown, current averaging, hall decode and sector counter
// ----------------------------------------------------------------------------
`default_nettype none

module hsat_track
   import hsat_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic [HALL_W-1:0]   hall,
   input  wire logic [PWM_W-1:0]    pwm,
   input  wire logic                calib_load,
   input  wire logic [CSR_W-1:0]    calib_value,
   output trk_type                  trk
);

   logic [CSR_W-1:0]       calib_left_ff, calib_left_in;
   logic [CURRENT_W-1:0]   current_ff, current_in;
   logic [POS_W-1:0]       position_ff, position_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   trk_type                trk_ff, trk_in;

   logic                   pwm_neg;
   logic                   pwm_zero;
   logic                   calibrating;
   logic [CURRENT_W-1:0]   shifted;
   logic [CURRENT_W:0]     avg_sum;
   logic [POS_W-1:0]       decoded;
   logic                   moved;

   assign pwm_neg     = pwm[PWM_W-1];
   assign pwm_zero    = (pwm == '0);
   assign calibrating = (calib_left_ff != '0);
   assign shifted     = {sample, 4'b0000};
   assign avg_sum     = {1'b0, shifted} + {1'b0, current_ff};
   assign decoded     = HALL_POS_TABLE[hall];
   assign moved       = !calibrating && (decoded != position_ff);

   always_comb begin
      calib_left_in = calib_left_ff;
      current_in    = current_ff;
      position_in   = position_ff;
      count_in      = count_ff;
      if (fire) begin
         if (calibrating) begin
            calib_left_in = calib_left_ff - 1'b1;
            current_in    = avg_sum[CURRENT_W:1];
         end else begin
            current_in  = shifted;
            position_in = decoded;
            if (moved && !pwm_neg && position_ff == POS_WRAP_HIGH
                && decoded < POS_WRAP_HIGH) begin
               count_in = count_ff + 1'b1;
            end else if (moved && (pwm_neg || pwm_zero) && position_ff == POS_WRAP_LOW
                         && decoded > POS_WRAP_LOW) begin
               count_in = count_ff - 1'b1;
            end
         end
      end
      if (calib_load) begin
         calib_left_in = calib_value;
      end
   end

   always_comb begin
      trk_in          = trk_ff;
      trk_in.current  = current_in;
      trk_in.position = position_in;
      trk_in.count    = count_in;
      trk_in.ready    = !calibrating;
      trk_in.moved    = moved;
      trk_in.pwm_neg  = pwm_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_left_ff <= CALIB_SAMPLES_RST;
         current_ff    <= '0;
         position_ff   <= '0;
         count_ff      <= '0;
      end else begin
         calib_left_ff <= calib_left_in;
         current_ff    <= current_in;
         position_ff   <= position_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         trk_ff <= trk_in;
      end
   end

   assign trk = trk_ff;

`ifndef SYNTHESIS
   a_calib_count_down: assert property (@(posedge clock) disable iff (reset)
      (fire && calibrating && !calib_load) |=> calib_left_ff == $past(calib_left_ff) - 1'b1)
      else $error("calibration countdown did not step");

   a_position_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(position_ff) && $stable(count_ff))
      else $error("tracker state changed without an accepted word");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      fire |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1'b1
               || count_ff == $past(count_ff) - 1'b1))
      else $error("sector counter moved by more than one");

   a_calib_holds_position: assert property (@(posedge clock) disable iff (reset)
      (fire && calibrating) |=> $stable(position_ff) && !trk_ff.moved)
      else $error("position changed during calibration");
`endif

endmodule

`default_nettype wire

// ===== rtl/hsat_angle.sv =====
// ----------------------------------------------------------------------------
// hsat_angle
// product stage and angle sum stage with the held angle as output register
// ----------------------------------------------------------------------------
`default_nettype none

module hsat_angle
   import hsat_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   trk_valid,
   input  wire trk_type                trk,
   input  wire logic [CSR_W-1:0]       sector_size,
   input  wire logic [CSR_W-1:0]       step_size,
   output logic                        out_valid,
   output trk_type                     out_trk,
   output logic [ANGLE_WIDTH-1:0]      out_angle
);

   logic                          prod_valid_ff;
   trk_type                       prod_trk_ff;
   logic signed [SEC_PROD_W-1:0]  sec_prod_ff, sec_prod_in;
   logic [POS_PROD_W-1:0]         pos_prod_ff, pos_prod_in;

   logic                          out_valid_ff;
   trk_type                       out_trk_ff;
   logic [ANGLE_WIDTH-1:0]        angle_store_ff, angle_store_in;
   logic [ANGLE_WIDTH-1:0]        pos_term;
   logic [ANGLE_WIDTH-1:0]        sec_term;

   assign sec_prod_in = $signed(trk.count) * $signed({1'b0, sector_size});
   assign pos_prod_in = trk.position * step_size;

   assign sec_term = ANGLE_WIDTH'(sec_prod_ff);
   assign pos_term = ANGLE_WIDTH'(pos_prod_ff);

   always_comb begin
      angle_store_in = angle_store_ff;
      if (prod_trk_ff.moved) begin
         if (prod_trk_ff.pwm_neg) begin
            angle_store_in = sec_term - pos_term;
         end else begin
            angle_store_in = sec_term + pos_term;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
         angle_store_ff <= '0;
      end else if (advance) begin
         prod_valid_ff <= trk_valid;
         out_valid_ff  <= prod_valid_ff;
         if (prod_valid_ff) begin
            angle_store_ff <= angle_store_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && trk_valid) begin
         prod_trk_ff <= trk;
         sec_prod_ff <= sec_prod_in;
         pos_prod_ff <= pos_prod_in;
      end
      if (advance && prod_valid_ff) begin
         out_trk_ff <= prod_trk_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_trk   = out_trk_ff;
   assign out_angle = angle_store_ff;

`ifndef SYNTHESIS
   a_angle_held: assert property (@(posedge clock) disable iff (reset)
      !(advance && prod_valid_ff && prod_trk_ff.moved) |=> $stable(angle_store_ff))
      else $error("angle changed without a position move");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !advance) |=> out_valid_ff && $stable(out_trk_ff))
      else $error("result word changed under stall");

   a_move_ready: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_trk_ff.ready || !out_trk_ff.moved))
      else $error("move reported while calibrating");
`endif

endmodule

`default_nettype wire

// ===== rtl/hall_sector_angle_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// hall_sector_angle_tracker_unit
// hall sensor rotor angle tracker with current calibration averaging
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | req_tdata: current, hall, pwm
//  rsp     | out | rsp_tvalid/tready  | rsp_tdata: current, pos, count, angle, status, moved
//  csr     | in  | csr_wen            | csr_index, csr_wdata
//
//  one word per cycle sustained while the result is not stalled
//  stages: tracker state update, sector and step multipliers, angle sum
//  a stalled result holds the whole pipeline; req_tready follows rsp side
//  synchronous active-high reset loads calibration length and CSR defaults and clears state
// ----------------------------------------------------------------------------
`default_nettype none

module hall_sector_angle_tracker_unit
   import hsat_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // current_sample[11:0], hall_bits[14:12], pwm_drive[30:15]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // current_value[15:0], hall_position[18:16], sector_count[34:19],
   // rotor_angle[66:35], status_code[67], position_moved[68]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_wen,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]      csr_wdata
);

   logic [CSR_W-1:0]       sector_size_ff;
   logic [CSR_W-1:0]       step_size_ff;

   logic                   advance;
   logic                   fire;
   logic                   trk_valid_ff;
   logic                   calib_load;
   trk_type                trk;
   logic                   out_valid;
   trk_type                out_trk;
   logic [ANGLE_WIDTH-1:0] out_angle;

   assign advance    = !out_valid || rsp_tready;
   assign req_tready = advance;
   assign fire       = req_tvalid && advance;
   assign calib_load = csr_wen && (csr_index == CSR_CALIB_SAMPLES);

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_size_ff   <= SECTOR_SIZE_RST;
         step_size_ff     <= STEP_SIZE_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_SECTOR_SIZE:   sector_size_ff   <= csr_wdata;
            CSR_STEP_SIZE:     step_size_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trk_valid_ff <= 1'b0;
      end else if (advance) begin
         trk_valid_ff <= req_tvalid;
      end
   end

   hsat_track u_track (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .sample      (req_tdata[11:0]),
      .hall        (req_tdata[14:12]),
      .pwm         (req_tdata[30:15]),
      .calib_load  (calib_load),
      .calib_value (csr_wdata),
      .trk         (trk)
   );

   hsat_angle u_angle (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .trk_valid   (trk_valid_ff),
      .trk         (trk),
      .sector_size (sector_size_ff),
      .step_size   (step_size_ff),
      .out_valid   (out_valid),
      .out_trk     (out_trk),
      .out_angle   (out_angle)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {3'b000,
                        out_trk.moved,
                        out_trk.ready,
                        32'(out_angle),
                        16'(out_trk.count),
                        out_trk.position,
                        out_trk.current};

`ifndef SYNTHESIS
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !fire)
      else $error("word accepted while result stalled");

   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      (fire && advance) |=> trk_valid_ff)
      else $error("accepted word lost in pipeline");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped under stall");
`endif

endmodule

`default_nettype wire
